[hdl/hnt_pkg.sv]
// hnt_pkg: shared types, constants and the case-folding function
// for the hashed name table; used by hnt_ctrl, hnt_datapath and hashed_name_table
package hnt_pkg;

    localparam int HASH_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int VALUE_IN_W = 16;
    localparam int STATUS_W = 2;

    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;

    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FIND = 1'b1;

    localparam logic [STATUS_W-1:0] ST_STORED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic take;
        logic take_last;
        logic read_en;
        logic scan_next;
        logic capture_hit;
        logic commit;
    } hnt_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic scan_last;
        logic key_match;
        logic out_busy;
    } hnt_sts_t;

    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

[hdl/hnt_ctrl.sv]
// hnt_ctrl: state machine that sequences byte intake, key scan and commit
// depends on hnt_pkg (command and status structs)
module hnt_ctrl
    import hnt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_last,
    output logic     s_ready,
    input  hnt_sts_t sts,
    output hnt_cmd_t cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_CMP    = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE: begin
                cmd.take = s_valid;
                cmd.take_last = s_valid & s_last;
                if (s_valid && s_last) begin
                    state_next = sts.count_zero ? S_COMMIT : S_READ;
                end
            end
            S_READ: begin
                cmd.read_en = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                priority if (sts.key_match) begin
                    cmd.capture_hit = 1'b1;
                    state_next = S_COMMIT;
                end else if (sts.scan_last) begin
                    state_next = S_COMMIT;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next = S_READ;
                end
            end
            S_COMMIT: begin
                if (!sts.out_busy) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // scan always ends in a commit before new bytes are taken
    a_cmp_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> $past(state_reg) == S_READ)
        else $error("compare state entered without a table read");

    a_commit_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (state_reg == S_IDLE))
        else $error("controller did not return to idle after commit");

    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !sts.out_busy)
        else $error("commit while the result slot is held");

endmodule

[hdl/hnt_datapath.sv]
// hnt_datapath: running hash, key and value memories, scan pointer, entry count
// and the result register; depends on hnt_pkg, driven by hnt_ctrl commands
module hnt_datapath
    import hnt_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  hnt_cmd_t              cmd,
    output hnt_sts_t              sts,
    input  logic                  in_action,
    input  logic [BYTE_W-1:0]     in_byte,
    input  logic                  in_present,
    input  logic [VALUE_IN_W-1:0] in_value,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [STATUS_W-1:0]   out_status,
    output logic [VALUE_IN_W-1:0] out_value,
    output logic [HASH_W-1:0]     out_hash
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic [HASH_W-1:0]     key_mem [CAPACITY];
    logic [VALUE_BITS-1:0] val_mem [CAPACITY];

    logic [HASH_W-1:0]     hash_reg;
    logic [HASH_W-1:0]     hash_next;
    logic [HASH_W-1:0]     key_reg;
    logic                  action_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_in;
    logic [ADDR_W-1:0]     addr_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      addr_inc;
    logic [HASH_W-1:0]     rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic                  hit_reg;
    logic [ADDR_W-1:0]     hit_idx_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;
    logic                  full;
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   out_status_reg;
    logic [VALUE_BITS-1:0] out_val_reg;
    logic [HASH_W-1:0]     out_hash_reg;
    logic                  add_new;
    logic                  val_we;
    logic [ADDR_W-1:0]     val_waddr;
    logic [STATUS_W-1:0]   status_next;

    generate
        if (VALUE_BITS <= VALUE_IN_W) begin : g_narrow
            assign value_in = in_value[VALUE_BITS-1:0];
            if (VALUE_BITS < VALUE_IN_W) begin : g_pad
                assign out_value = {{(VALUE_IN_W-VALUE_BITS){1'b0}}, out_val_reg};
            end else begin : g_same
                assign out_value = out_val_reg;
            end
        end else begin : g_wide
            assign value_in = {{(VALUE_BITS-VALUE_IN_W){1'b0}}, in_value};
            assign out_value = out_val_reg[VALUE_IN_W-1:0];
        end
    endgenerate

    // hash * 33 xor folded byte, when the byte is present
    always_comb begin
        hash_next = hash_reg;
        if (in_present) begin
            hash_next = ((hash_reg << 5) + hash_reg)
                      ^ {{(HASH_W-BYTE_W){1'b0}}, fold_case(in_byte)};
        end
    end

    assign addr_inc = CNT_W'(addr_reg) + CNT_W'(1);
    assign full = (count_reg == CNT_W'(CAPACITY));

    assign sts.count_zero = (count_reg == '0);
    assign sts.scan_last  = (addr_inc >= count_reg);
    assign sts.key_match  = (rd_key_reg == key_reg);
    assign sts.out_busy   = out_valid_reg & ~out_ready;

    assign add_new   = (action_reg == ACT_ADD) & ~hit_reg & ~full;
    assign val_we    = cmd.commit & (action_reg == ACT_ADD) & (hit_reg | ~full);
    assign val_waddr = hit_reg ? hit_idx_reg : count_reg[ADDR_W-1:0];

    always_comb begin
        if (action_reg == ACT_ADD) begin
            status_next = (hit_reg || !full) ? ST_STORED : ST_FULL;
        end else begin
            status_next = hit_reg ? ST_FOUND : ST_NOT_FOUND;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg      <= HASH_SEED;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            addr_reg      <= '0;
        end else begin
            if (cmd.take_last) begin
                hash_reg <= HASH_SEED;
                hit_reg  <= 1'b0;
                addr_reg <= '0;
            end else if (cmd.take) begin
                hash_reg <= hash_next;
            end
            if (cmd.scan_next) begin
                addr_reg <= addr_reg + ADDR_W'(1);
            end
            if (cmd.capture_hit) begin
                hit_reg <= 1'b1;
            end
            if (cmd.commit && add_new) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.commit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.take_last) begin
            key_reg    <= hash_next;
            action_reg <= in_action;
            value_reg  <= value_in;
        end
        if (cmd.capture_hit) begin
            hit_idx_reg <= addr_reg;
            hit_val_reg <= rd_val_reg;
        end
        if (cmd.commit) begin
            out_status_reg <= status_next;
            out_hash_reg   <= key_reg;
            out_val_reg    <= (action_reg == ACT_FIND && hit_reg) ? hit_val_reg : '0;
        end
    end

    // table memories
    always_ff @(posedge aclk) begin
        if (cmd.commit && add_new) begin
            key_mem[count_reg[ADDR_W-1:0]] <= key_reg;
        end
        if (cmd.read_en) begin
            rd_key_reg <= key_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_waddr] <= value_reg;
        end
        if (cmd.read_en) begin
            rd_val_reg <= val_mem[addr_reg];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_hash   = out_hash_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_append_counts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && add_new) |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("append did not advance entry count");

    a_hash_reseed: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take_last |=> hash_reg == HASH_SEED)
        else $error("running hash not reseeded after end of name");

    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten before it was taken");

endmodule

[hdl/hashed_name_table.sv]
// hashed_name_table: name hash table top level, bytes in and one result per name out
// steps: a byte without end of name updates the running hash; at end of name the key scan
// reads stored entries one at a time up to a match or the last, then commits the result
// throughput: one name byte per cycle, new bytes wait until the scan has committed
// reset: running hash returns to 5381, table empty, no clearing pass, result slot empty
module hashed_name_table
    import hnt_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // name_byte, byte_present, entry_value, zero pad
    input  logic        s_axis_tuser,  // action
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // found_value, name_hash
    output logic [1:0]  m_axis_tuser   // status
);

    hnt_cmd_t              cmd;
    hnt_sts_t              sts;
    logic [VALUE_IN_W-1:0] out_value;
    logic [HASH_W-1:0]     out_hash;

    hnt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_last  (s_axis_tlast),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    hnt_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_action  (s_axis_tuser),
        .in_byte    (s_axis_tdata[7:0]),
        .in_present (s_axis_tdata[8]),
        .in_value   (s_axis_tdata[24:9]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_status (m_axis_tuser),
        .out_value  (out_value),
        .out_hash   (out_hash)
    );

    assign m_axis_tdata = {out_hash, out_value};

endmodule
